@@ sv/sitda_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the signed integer to decimal ASCII converter.
// No dependencies; used by the interfaces, the digit cell and the top level.
package sitda_pkg;

    // Input width and decimal digits needed to hold its magnitude
    localparam int DATA_W     = 32;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 8;
    localparam int BIT_CNT_W  = $clog2(DATA_W);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    // ASCII codes and radix
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
    localparam logic [DIGIT_W-1:0] RADIX      = 4'd10;

    // Add-3 threshold of the shift-and-add-3 conversion
    localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = 4'd5;
    localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd3;

    // Sequencer state codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // Control handed to every cell of the digit chain
    typedef struct packed {
        logic clear;        // zero the digit
        logic shift_bit;    // shift one binary bit in, with add-3 adjust
        logic shift_digit;  // take the lower neighbor's digit
    } cell_ctrl_t;

endpackage

@@ sv/sitda_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input integers and output characters.
// Depends on sitda_pkg for field widths.
interface sitda_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sitda_pkg::DATA_W-1:0]  signed_value;

    modport source (output valid, output signed_value, input ready);
    modport sink   (input valid, input signed_value, output ready);
endinterface

interface sitda_out_if;
    logic                          valid;
    logic                          ready;
    logic [sitda_pkg::CHAR_W-1:0]  character;
    logic                          last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

@@ sv/sitda_digit_cell.sv @@
`timescale 1ns / 1ps
// One BCD digit cell of the conversion chain: shift-and-add-3 step or digit shift.
// Depends on sitda_pkg for the control struct and constants.
module sitda_digit_cell
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  sitda_pkg::cell_ctrl_t               ctrl,
    input  logic                                carry_in,
    input  logic [sitda_pkg::DIGIT_W-1:0]       digit_in,
    output logic                                carry_out,
    output logic [sitda_pkg::DIGIT_W-1:0]       digit
);

    logic [sitda_pkg::DIGIT_W-1:0] digit_reg;
    logic [sitda_pkg::DIGIT_W-1:0] digit_next;
    logic [sitda_pkg::DIGIT_W-1:0] adj;

    // Adjust by three before doubling so the digit carries out at ten
    assign adj       = (digit_reg >= sitda_pkg::ADJ_LIMIT) ?
                       (digit_reg + sitda_pkg::ADJ_ADD) : digit_reg;
    assign carry_out = adj[sitda_pkg::DIGIT_W-1];
    assign digit     = digit_reg;

    // Select the next digit
    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.shift_bit)
        begin
            digit_next = {adj[sitda_pkg::DIGIT_W-2:0], carry_in};
        end
        else if (ctrl.shift_digit)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

@@ sv/signed_int_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
// Operation: the integer is loaded, then converted one input bit per cycle through the
// digit chain, then unloaded as a minus sign for a negative value followed by the
// ten-digit chain, with leading zeros skipped and each other character emitted.
// Input is taken only while the sequencer is idle, so a new integer is accepted only
// after the last character of the previous one has been issued.
// Reset: rst_n clears the sequencer, the digit chain and the output valid flag.
module signed_int_to_decimal_ascii
(
    input  logic            clk,
    input  logic            rst_n,
    sitda_in_if.sink        in_ch,
    sitda_out_if.source     out_ch
);

    localparam int ND = sitda_pkg::NUM_DIGITS;
    localparam int DW = sitda_pkg::DIGIT_W;

    logic [1:0]                        state_reg, state_next;
    logic [sitda_pkg::DATA_W-1:0]      mag_reg, mag_next;
    logic [sitda_pkg::BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [sitda_pkg::DIG_CNT_W-1:0]   dig_cnt_reg, dig_cnt_next;
    logic                              neg_reg, neg_next;
    logic                              sign_reg, sign_next;
    logic                              started_reg, started_next;
    logic                              ovalid_reg, ovalid_next;
    logic [sitda_pkg::CHAR_W-1:0]      ochar_reg, ochar_next;
    logic                              olast_reg, olast_next;

    sitda_pkg::cell_ctrl_t             ctrl;
    logic [ND:0]                       carry;
    logic [DW-1:0]                     digit_w [ND];
    logic [DW-1:0]                     top_digit;
    logic                              accept;
    logic                              out_free;
    logic                              emit_digit;
    logic                              skip_digit;
    logic                              last_digit;

    // Digit chain: carry ripples upward on a bit shift, digits move up on unload
    assign carry[0] = mag_reg[sitda_pkg::DATA_W-1];

    for (genvar i = 0; i < ND; i++)
    begin : g_cell
        logic [DW-1:0] lower_digit;
        if (i == 0)
        begin : g_low
            assign lower_digit = '0;
        end
        else
        begin : g_mid
            assign lower_digit = digit_w[i-1];
        end

        sitda_digit_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .carry_in  (carry[i]),
            .digit_in  (lower_digit),
            .carry_out (carry[i+1]),
            .digit     (digit_w[i])
        );
    end

    assign top_digit = digit_w[ND-1];

    // Handshake
    assign in_ch.ready      = (state_reg == sitda_pkg::ST_IDLE);
    assign accept           = in_ch.valid && in_ch.ready;
    assign out_free         = !ovalid_reg || out_ch.ready;
    assign out_ch.valid     = ovalid_reg;
    assign out_ch.character = ochar_reg;
    assign out_ch.last_char = olast_reg;

    // Unload decisions: drop leading zeros, keep the last digit always
    assign last_digit = (dig_cnt_reg == sitda_pkg::DIG_CNT_W'(1));
    assign skip_digit = (state_reg == sitda_pkg::ST_EMIT) && !sign_reg && !started_reg
                        && (top_digit == '0) && !last_digit;
    assign emit_digit = (state_reg == sitda_pkg::ST_EMIT) && !sign_reg && !skip_digit
                        && out_free;

    // Cell control
    always_comb
    begin
        ctrl.clear       = accept;
        ctrl.shift_bit   = (state_reg == sitda_pkg::ST_CONV);
        ctrl.shift_digit = skip_digit || emit_digit;
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        neg_next     = neg_reg;
        sign_next    = sign_reg;
        started_next = started_reg;
        ovalid_next  = ovalid_reg && !out_ch.ready;
        ochar_next   = ochar_reg;
        olast_next   = olast_reg;

        case (state_reg)
            sitda_pkg::ST_IDLE:
            begin
                // Load the magnitude; negation of the most negative value wraps to 2^31
                if (accept)
                begin
                    neg_next     = in_ch.signed_value[sitda_pkg::DATA_W-1];
                    mag_next     = neg_next ? (~in_ch.signed_value + 1'b1)
                                            : in_ch.signed_value;
                    bit_cnt_next = '0;
                    state_next   = sitda_pkg::ST_CONV;
                end
            end
            sitda_pkg::ST_CONV:
            begin
                // Advance one bit into the chain
                mag_next     = {mag_reg[sitda_pkg::DATA_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == sitda_pkg::BIT_CNT_W'(sitda_pkg::DATA_W - 1))
                begin
                    dig_cnt_next = sitda_pkg::DIG_CNT_W'(ND);
                    sign_next    = neg_reg;
                    started_next = 1'b0;
                    state_next   = sitda_pkg::ST_EMIT;
                end
            end
            sitda_pkg::ST_EMIT:
            begin
                if (sign_reg && out_free)
                begin
                    ovalid_next = 1'b1;
                    ochar_next  = sitda_pkg::CHAR_MINUS;
                    olast_next  = 1'b0;
                    sign_next   = 1'b0;
                end
                else if (skip_digit)
                begin
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
                else if (emit_digit)
                begin
                    ovalid_next  = 1'b1;
                    ochar_next   = sitda_pkg::CHAR_ZERO + {4'b0000, top_digit};
                    olast_next   = last_digit;
                    started_next = 1'b1;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                    if (last_digit)
                    begin
                        state_next = sitda_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sitda_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sitda_pkg::ST_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
            sign_reg    <= 1'b0;
            started_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            sign_reg    <= sign_next;
            started_reg <= started_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

`ifndef SYNTH
    // A 32-bit magnitude never overflows the top digit
    a_no_top_carry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sitda_pkg::ST_CONV) |-> !carry[ND])
        else $error("carry out of the top digit cell");

    // Every digit reaching the top of the chain is decimal
    a_top_bcd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sitda_pkg::ST_EMIT) |-> (top_digit < sitda_pkg::RADIX))
        else $error("top digit is not a decimal digit");

    // An accepted transaction starts the conversion from bit zero
    a_start_conv: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == sitda_pkg::ST_CONV) && (bit_cnt_reg == '0))
        else $error("conversion did not start after accept");

    // The final digit returns the sequencer to idle, flagged as last
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_digit && last_digit) |=> (state_reg == sitda_pkg::ST_IDLE)
                                       && ovalid_reg && olast_reg)
        else $error("final digit did not end the string");
`endif

endmodule

@@ verif/tb_signed_int_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
// Testbench for signed_int_to_decimal_ascii: drives 32-bit integers and checks each ASCII
// character against known text or a local decimal formatter. Depends on sitda_pkg, sitda_if and the RTL.
module tb_signed_int_to_decimal_ascii;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int FIRST_RANDOM  = 100;
    localparam int SECOND_RANDOM = 210;
    localparam int NUM_DIRECTED  = 21;

    typedef struct packed {
        logic [sitda_pkg::CHAR_W-1:0] character;
        logic                         last_char;
    } ascii_char_t;

    logic clk;
    logic rst_n;

    sitda_in_if  in_ch ();
    sitda_out_if out_ch ();

    signed_int_to_decimal_ascii i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Characters still owed by the block, oldest first
    ascii_char_t pending_chars[$];
    int          mismatch_count;
    bit          source_gaps;
    bit          sink_stalls;

    // Directed values; a non-empty text is the known answer, empty means use the formatter
    logic signed [sitda_pkg::DATA_W-1:0] directed_values [NUM_DIRECTED] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10,
        32'sd2147483647, 32'h8000_0000, -32'sd2147483647,
        32'sd1000000000, 32'sd999999999, -32'sd1000000000,
        32'sd1234567890, -32'sd987654321, 32'h5555_5555, 32'hAAAA_AAAA,
        32'sd100, -32'sd99, 32'sd65535, -32'sd65536, 32'sd7
    };
    string directed_text [NUM_DIRECTED] = '{
        "0", "1", "-1", "9", "10", "-10",
        "2147483647", "-2147483648", "-2147483647",
        "1000000000", "", "",
        "", "", "", "",
        "", "", "", "", ""
    };

    // Clock
    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Queue the decimal text of one integer: sign, then digits most significant first
    function automatic void format_decimal(input logic signed [sitda_pkg::DATA_W-1:0] value);
        logic [sitda_pkg::DATA_W-1:0]  mag;
        logic [sitda_pkg::DIGIT_W-1:0] digits [sitda_pkg::NUM_DIGITS];
        int                            count;
        ascii_char_t                   ch;
        mag   = value[sitda_pkg::DATA_W-1] ? (~value + 1'b1) : value;
        count = 0;
        if (mag == '0)
        begin
            ch.character = sitda_pkg::CHAR_ZERO;
            ch.last_char = 1'b1;
            pending_chars.push_back(ch);
            return;
        end
        while (mag != '0 && count < sitda_pkg::NUM_DIGITS)
        begin
            digits[count] = sitda_pkg::DIGIT_W'(mag % sitda_pkg::RADIX);
            mag           = mag / sitda_pkg::RADIX;
            count++;
        end
        if (value[sitda_pkg::DATA_W-1])
        begin
            ch.character = sitda_pkg::CHAR_MINUS;
            ch.last_char = 1'b0;
            pending_chars.push_back(ch);
        end
        for (int i = count - 1; i >= 0; i--)
        begin
            ch.character = sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_W'(digits[i]);
            ch.last_char = (i == 0);
            pending_chars.push_back(ch);
        end
    endfunction

    // Queue a known answer typed as text
    function automatic void expect_text(input string text);
        ascii_char_t ch;
        for (int i = 0; i < text.len(); i++)
        begin
            ch.character = sitda_pkg::CHAR_W'(text[i]);
            ch.last_char = (i == text.len() - 1);
            pending_chars.push_back(ch);
        end
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 60);
    endfunction

    // Pick a value: full random, a chosen digit count with random sign, or an edge value
    function automatic logic signed [sitda_pkg::DATA_W-1:0] draw_value();
        int                                  r;
        int                                  ndig;
        longint                              lo;
        longint                              hi;
        logic signed [sitda_pkg::DATA_W-1:0] v;
        r = $urandom_range(0, 9);
        if (r < 3)
            return $urandom();
        if (r == 9)
        begin
            case ($urandom_range(0, 5))
                0: v = 32'sd0;
                1: v = -32'sd1;
                2: v = 32'sd2147483647;
                3: v = 32'h8000_0000;
                4: v = 32'sd1000000000;
                default: v = -32'sd999999999;
            endcase
            return v;
        end
        ndig = $urandom_range(1, sitda_pkg::NUM_DIGITS);
        lo   = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi   = (ndig == sitda_pkg::NUM_DIGITS) ? 64'd2147483647 : lo * 10 - 1;
        if (ndig == 1)
            lo = 0;
        v = $urandom_range(32'(hi), 32'(lo));
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    // Present one integer and hold it until the transaction completes
    task automatic send_value(input logic signed [sitda_pkg::DATA_W-1:0] value,
                              input string text);
        int gap;
        gap = source_gaps ? draw_gap() : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.signed_value <= value;
        in_ch.valid        <= 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (text != "")
            expect_text(text);
        else
            format_decimal(value);
    endtask

    // Sink side: random stall runs while enabled, otherwise always ready
    initial
    begin
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (sink_stalls && $urandom_range(0, 3) == 0)
                    stall_left = draw_gap();
            end
        end
    end

    // Compare each output transaction with the oldest pending character
    always @(posedge clk)
    begin
        ascii_char_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_chars.size() == 0)
                report_mismatch($sformatf("unexpected character %0d last %0b",
                                          out_ch.character, out_ch.last_char));
            else
            begin
                want = pending_chars.pop_front();
                if (out_ch.character !== want.character)
                    report_mismatch($sformatf("character got %0d want %0d",
                                              out_ch.character, want.character));
                if (out_ch.last_char !== want.last_char)
                    report_mismatch($sformatf("last_char got %0b want %0b on char %0d",
                                              out_ch.last_char, want.last_char,
                                              want.character));
            end
        end
    end

    // Watchdog: end the run when no transaction happens for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Main sequence
    initial
    begin
        mismatch_count     = 0;
        source_gaps        = 1'b1;
        sink_stalls        = 1'b1;
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.signed_value = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_value(directed_values[i], directed_text[i]);

        // Back-to-back random traffic with no idling on either side
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        for (int i = 0; i < FIRST_RANDOM; i++)
            send_value(draw_value(), "");

        // Hold off the sender until the block has drained
        in_ch.valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);

        // Random traffic with gaps and stalls
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        for (int i = 0; i < SECOND_RANDOM; i++)
            send_value(draw_value(), "");
        in_ch.valid <= 1'b0;

        // Drain, then watch for stray characters
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_chars.size() != 0)
            report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
